[rtl/iqns_pkg.sv]
// iqns_pkg: shared types and constants of the iq noise scrambler
// no dependencies; used by the interfaces and every rtl module
`default_nettype none

package iqns_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned PADDR_W = 3;

    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic [WORD_W-1:0]        t_word;
    typedef logic signed [WORD_W-1:0] t_sample;

    // message kinds
    localparam t_mode MODE_IQ   = 2'd0;
    localparam t_mode MODE_SYNC = 2'd1;
    localparam t_mode MODE_TIME = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_NOISE_MASK = 1'b0;

    localparam t_word NOISE_MASK_RESET = 16'h0000;
    localparam t_word WORD_I_RESET     = 16'h0001;
    localparam t_word WORD_Q_RESET     = 16'h2267;
    localparam t_word SEED_KEEP_MASK   = 16'h7FFE;

    typedef struct packed {
        t_word word_i;
        t_word word_q;
    } t_noise_words;

    typedef struct packed {
        t_mode   mode;
        logic    first_of_message;
        t_sample sample_i;
        t_sample sample_q;
    } t_in_item;

    typedef struct packed {
        t_mode   kind_out;
        t_sample result_i;
        t_sample result_q;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/iqns_if.sv]
// iqns_in_if / iqns_out_if: valid-ready stream channels of the scrambler
// depends on iqns_pkg
`default_nettype none

interface iqns_in_if;
    logic                 valid;
    logic                 ready;
    iqns_pkg::t_mode      mode;
    logic                 first_of_message;
    iqns_pkg::t_sample    sample_i;
    iqns_pkg::t_sample    sample_q;

    modport source (output valid, output mode, output first_of_message,
                    output sample_i, output sample_q, input ready);
    modport sink   (input valid, input mode, input first_of_message,
                    input sample_i, input sample_q, output ready);
endinterface

interface iqns_out_if;
    logic                 valid;
    logic                 ready;
    iqns_pkg::t_mode      kind_out;
    iqns_pkg::t_sample    result_i;
    iqns_pkg::t_sample    result_q;

    modport source (output valid, output kind_out, output result_i,
                    output result_q, input ready);
    modport sink   (input valid, input kind_out, input result_i,
                    input result_q, output ready);
endinterface

`default_nettype wire

[rtl/iqns_cfg_regs.sv]
// iqns_cfg_regs: apb-style register port holding the noise mask
// depends on iqns_pkg
`default_nettype none

module iqns_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [iqns_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [iqns_pkg::PDATA_W-1:0]        pwdata,
    output logic      [iqns_pkg::PDATA_W-1:0]        prdata,
    output logic                                     pready,
    output iqns_pkg::t_word                          o_noise_mask
);

    iqns_pkg::t_word r_noise_mask;
    logic            w_sel_mask;
    logic            w_wr;

    assign pready     = 1'b1;
    assign w_sel_mask = (paddr[2] == iqns_pkg::REG_NOISE_MASK);
    assign w_wr       = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_mask <= iqns_pkg::NOISE_MASK_RESET;
        end else if (w_wr && w_sel_mask) begin
            r_noise_mask <= pwdata[iqns_pkg::WORD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_mask) begin
            prdata[iqns_pkg::WORD_W-1:0] = r_noise_mask;
        end
    end

    assign o_noise_mask = r_noise_mask;

endmodule

`default_nettype wire

[rtl/iqns_noise_gen.sv]
// iqns_noise_gen: the two generator words and their bit-shuffle advance
// depends on iqns_pkg
`default_nettype none

module iqns_noise_gen (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    output iqns_pkg::t_noise_words      o_words
);

    iqns_pkg::t_noise_words r_words;
    iqns_pkg::t_noise_words n_words;

    // each bit update sees the bits written before it, i first, then q
    function automatic iqns_pkg::t_noise_words shuffle(iqns_pkg::t_noise_words w);
        iqns_pkg::t_word a;
        iqns_pkg::t_word b;
        iqns_pkg::t_noise_words r;
        a = w.word_i & iqns_pkg::SEED_KEEP_MASK;
        a[0] = w.word_i[14] ^ w.word_i[13];
        b = w.word_q & iqns_pkg::SEED_KEEP_MASK;
        b[0] = w.word_q[14] ^ w.word_q[13];

        a[15] = b[14] & a[3];
        a[14] = a[8] | a[11];
        a[13] = a[3] ^ b[4];
        a[12] = ~b[13];
        a[11] = a[12];
        a[10] = b[13];
        a[9]  = b[5] ^ a[6];
        a[8]  = a[2] & a[7];
        a[7]  = a[14] ^ b[3];
        a[6]  = a[7];
        a[5]  = a[9] | a[8];
        a[4]  = a[6] & a[1];
        a[3]  = b[2] & b[0];
        a[2]  = b[1];
        a[1]  = ~b[3];
        a[0]  = a[11] | a[8];

        b[15] = a[14];
        b[14] = b[5] & a[2];
        b[13] = a[1] ^ a[0];
        b[12] = b[12];
        b[11] = a[1] ^ a[0];
        b[10] = b[12];
        b[9]  = b[13] | a[5];
        b[8]  = b[4];
        b[7]  = ~a[7];
        b[6]  = ~b[6];
        b[5]  = b[5];
        b[4]  = a[4] & a[8];
        b[3]  = b[1] & a[7];
        b[2]  = a[13];
        b[1]  = a[9];
        b[0]  = ~b[12];

        r.word_i = a;
        r.word_q = b;
        return r;
    endfunction

    assign n_words = shuffle(r_words);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words.word_i <= iqns_pkg::WORD_I_RESET;
            r_words.word_q <= iqns_pkg::WORD_Q_RESET;
        end else if (i_step) begin
            r_words <= n_words;
        end
    end

    // the message start uses the words already advanced
    assign o_words = i_step ? n_words : r_words;

endmodule

`default_nettype wire

[rtl/iq_noise_scrambler_top.sv]
// iq_noise_scrambler_top: input register, generator, xor stage and result register
// depends on iqns_pkg, iqns_if, iqns_cfg_regs, iqns_noise_gen
//
//   channel   direction  transaction carries
//   in_ch     in         mode, first_of_message, sample_i, sample_q
//   out_ch    out        kind_out, result_i, result_q
//   apb       in/out     noise_mask at byte address 0
//
// two register stages: an item is captured in the input register, then the
// generator advance and the xor run combinationally into the result register
// one item per cycle while out_ch does not stall
// in_ch.ready stays high while the input register is empty or the result register is free or being drained
// a stall on out_ch holds both stages; the generator only moves with an item
// synchronous active-low reset empties both stages and reloads the words
`default_nettype none

module iq_noise_scrambler_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    iqns_in_if.sink                                 in_ch,
    iqns_out_if.source                              out_ch,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [iqns_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [iqns_pkg::PDATA_W-1:0]       pwdata,
    output logic      [iqns_pkg::PDATA_W-1:0]       prdata,
    output logic                                    pready
);

    iqns_pkg::t_word        w_noise_mask;
    iqns_pkg::t_noise_words w_words;

    logic                   r_in_valid;
    iqns_pkg::t_in_item     r_in;
    logic                   r_out_valid;
    iqns_pkg::t_out_item    r_out;
    iqns_pkg::t_out_item    n_out;

    logic                   w_adv;    // result register can take a new item
    logic                   w_move;   // input stage hands its item over
    logic                   w_step;   // iq message start advances the words
    logic                   w_is_iq;
    iqns_pkg::t_word        w_apply_i;
    iqns_pkg::t_word        w_apply_q;

    // configuration register port
    iqns_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_noise_mask (w_noise_mask)
    );

    // pipeline flow control
    assign w_adv       = !r_out_valid || out_ch.ready;
    assign w_move      = r_in_valid && w_adv;
    assign in_ch.ready = !r_in_valid || w_adv;

    assign w_is_iq = (r_in.mode == iqns_pkg::MODE_IQ);
    assign w_step  = w_move && w_is_iq && r_in.first_of_message;

    // generator words, already advanced when this item starts a message
    iqns_noise_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_words (w_words)
    );

    // sync, time and undefined kinds pass through untouched
    assign w_apply_i = w_is_iq ? (w_words.word_i & w_noise_mask) : '0;
    assign w_apply_q = w_is_iq ? (w_words.word_q & w_noise_mask) : '0;

    always_comb begin
        n_out.kind_out = r_in.mode;
        n_out.result_i = r_in.sample_i ^ $signed(w_apply_i);
        n_out.result_q = r_in.sample_q ^ $signed(w_apply_q);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_in_valid <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_in.mode             <= in_ch.mode;
            r_in.first_of_message <= in_ch.first_of_message;
            r_in.sample_i         <= in_ch.sample_i;
            r_in.sample_q         <= in_ch.sample_q;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign out_ch.valid    = r_out_valid;
    assign out_ch.kind_out = r_out.kind_out;
    assign out_ch.result_i = r_out.result_i;
    assign out_ch.result_q = r_out.result_q;

`ifndef SYNTHESIS
    // words must not move unless an iq message start is handed over
    a_words_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(u_gen.o_words) || $past(w_step) || w_step)
        else $error("generator words moved without an iq message start");

    // non-iq items reach the result register unchanged
    a_non_iq_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && !w_is_iq) |=> (r_out.result_i == $past(r_in.sample_i))
            && (r_out.result_q == $past(r_in.sample_q)))
        else $error("sync or time item was scrambled");

    // a zero mask leaves samples untouched
    a_zero_mask_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (w_noise_mask == '0)) |=> (r_out.result_i == $past(r_in.sample_i))
            && (r_out.result_q == $past(r_in.sample_q)))
        else $error("sample changed with zero noise mask");

    // a handed-over item always lands as a valid result with its kind
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid && (r_out.kind_out == $past(r_in.mode)))
        else $error("item lost between input and result registers");
`endif

endmodule

`default_nettype wire
